>>> rtl/sips_pkg.sv
// Shared types and constants for the sorted insert-position search block.
// No dependencies; compile first.
`default_nettype none

package sips_pkg;

	// Fixed field widths
	localparam int unsigned OP_W  = 2;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned POS_W = 11;

	// Default table depth
	localparam int unsigned DEF_TABLE_DEPTH = 1024;

	// Item operations; the fourth code is unused and ignored
	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear;   // empty the table
		logic append;  // write key at the end, set append result
		logic start;   // capture query key, open search range
		logic probe;   // read the middle entry of the range
		logic step;    // compare and narrow the range
		logic emit;    // move the result into the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;   // table holds no entries
		logic done;    // search ends after this compare
	} status_t;

endpackage

`default_nettype wire

>>> rtl/sips_if.sv
// Valid/ready channel interfaces for the search block's item and result beats.
// Depends on sips_pkg for field widths.
`default_nettype none

interface sips_in_if;
	logic                               valid;
	logic                               ready;
	logic [sips_pkg::OP_W-1:0]          opcode;
	logic signed [sips_pkg::KEY_W-1:0]  key;

	modport source (output valid, output opcode, output key, input ready);
	modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface sips_out_if;
	logic                        valid;
	logic                        ready;
	logic [sips_pkg::POS_W-1:0]  position;
	logic                        found;
	logic                        overflow;

	modport source (output valid, output position, output found, output overflow, input ready);
	modport sink   (input valid, input position, input found, input overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/sips_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module sips_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, register the read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

>>> rtl/sips_dp.sv
// Datapath: key table, entry count, search range, result and output registers.
// Depends on sips_pkg and sips_ram.
`default_nettype none

module sips_dp #(
	parameter int unsigned TABLE_DEPTH = sips_pkg::DEF_TABLE_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sips_pkg::cmd_t                    cmd,
	output sips_pkg::status_t                      st,
	input  wire logic signed [sips_pkg::KEY_W-1:0] in_key,
	output logic [sips_pkg::POS_W-1:0]             position,
	output logic                                   found,
	output logic                                   overflow
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      lo_q;
	logic [CW-1:0]                      hx_q;    // exclusive upper bound
	logic [CW-1:0]                      mid_q;
	logic signed [sips_pkg::KEY_W-1:0]  key_q;
	logic [CW-1:0]                      res_pos_q;
	logic                               res_found_q;
	logic                               res_ovf_q;

	logic [CW-1:0]                      mid;
	logic [CW-1:0]                      lo_n;
	logic [CW-1:0]                      hx_n;
	logic                               full;
	logic                               key_eq;
	logic                               key_gt;
	logic                               ram_we;
	logic [AW-1:0]                      ram_addr;
	logic [sips_pkg::KEY_W-1:0]         ram_rdata;
	logic signed [sips_pkg::KEY_W-1:0]  entry;

	// Middle of the open range, rounding down
	assign mid  = lo_q + ((hx_q - lo_q - CW'(1)) >> 1);
	assign full = (count_q == CW'(TABLE_DEPTH));

	// Compare the probed entry against the query key, signed
	assign entry  = $signed(ram_rdata);
	assign key_eq = (key_q == entry);
	assign key_gt = (key_q > entry);
	assign lo_n   = key_gt ? (mid_q + CW'(1)) : lo_q;
	assign hx_n   = key_gt ? hx_q : mid_q;

	assign st.empty = (count_q == '0);
	assign st.done  = key_eq || !(lo_n < hx_n);

	// Share the single port between appends and probes
	assign ram_we   = cmd.append && !full;
	assign ram_addr = cmd.append ? count_q[AW-1:0] : mid[AW-1:0];

	sips_ram #(
		.WIDTH (sips_pkg::KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_key),
		.rdata (ram_rdata)
	);

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (ram_we) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Search range, probe index and working result
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			res_pos_q   <= count_q;
			res_found_q <= 1'b0;
			res_ovf_q   <= full;
		end
		if (cmd.start) begin
			key_q       <= in_key;
			lo_q        <= '0;
			hx_q        <= count_q;
			res_pos_q   <= '0;
			res_found_q <= 1'b0;
			res_ovf_q   <= 1'b0;
		end
		if (cmd.probe) begin
			mid_q <= mid;
		end
		if (cmd.step) begin
			lo_q        <= lo_n;
			hx_q        <= hx_n;
			res_pos_q   <= key_eq ? mid_q : lo_n;
			res_found_q <= key_eq;
		end
	end

	// Output register, loaded when the controller emits a beat
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			position <= sips_pkg::POS_W'(res_pos_q);
			found    <= res_found_q;
			overflow <= res_ovf_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sips_ctrl.sv
// Controller: sequences clear, append and query items and the output beat.
// Depends on sips_pkg.
`default_nettype none

module sips_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [sips_pkg::OP_W-1:0]   opcode,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output sips_pkg::cmd_t                   cmd,
	input  wire sips_pkg::status_t           st
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid || out_ready;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (sips_pkg::op_t'(opcode))
						sips_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						sips_pkg::OP_APPEND: begin
							cmd.append = 1'b1;
							state_n    = ST_RESP;
						end
						sips_pkg::OP_QUERY: begin
							cmd.start = 1'b1;
							state_n   = st.empty ? ST_RESP : ST_PROBE;
						end
						default: begin
							state_n = ST_IDLE;
						end
					endcase
				end
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				state_n   = ST_CMP;
			end
			ST_CMP: begin
				cmd.step = 1'b1;
				state_n  = st.done ? ST_RESP : ST_PROBE;
			end
			ST_RESP: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/sorted_insert_position_search.sv
// Sorted insert-position search. The block keeps a table of up to TABLE_DEPTH
// signed 32-bit keys, which the user must append in ascending order; the block
// does not enforce this. It answers queries with the index of a matching key
// or the position where it would be inserted. A clear beat returns nothing and
// leaves the block ready for the next item; an append beat returns the index
// written, or the entry count with overflow set when the table is full. A
// query makes at most ceil(log2(n+1)) probes for n entries; each probe is one
// read of the single-port key RAM, whose read data is registered, followed by
// one compare. An empty table answers position 0 without a probe. A finished
// result sits in an output register, so the next item is taken while the
// result beat is still waiting.
// Depends on sips_pkg, sips_if, sips_ram, sips_dp and sips_ctrl.
`default_nettype none

module sorted_insert_position_search #(
	parameter int unsigned TABLE_DEPTH = sips_pkg::DEF_TABLE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sips_in_if.sink    req,
	sips_out_if.source rsp
);

	sips_pkg::cmd_t    cmd;
	sips_pkg::status_t st;

	sips_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.opcode    (req.opcode),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.st        (st)
	);

	sips_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.in_key   (req.key),
		.position (rsp.position),
		.found    (rsp.found),
		.overflow (rsp.overflow)
	);

endmodule

`default_nettype wire

>>> rtl/sips_chk.sv
// Port-level checks for the sorted insert-position search block, with its bind.
// Depends on sips_pkg and sorted_insert_position_search.
`default_nettype none

module sips_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic [sips_pkg::OP_W-1:0]   req_opcode,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic [sips_pkg::POS_W-1:0]  rsp_position,
	input wire logic                        rsp_found,
	input wire logic                        rsp_overflow
);

	logic req_beat;
	logic rsp_stall;

	assign req_beat  = req_valid && req_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;

	// Hold a stalled result beat unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_stall |=> rsp_valid && $stable(rsp_position) && $stable(rsp_found)
			&& $stable(rsp_overflow))
		else $error("result beat changed while stalled");

	// A result is never both a match and a dropped append
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_found && rsp_overflow))
		else $error("found and overflow both set");

	// An append or query occupies the block for at least the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && (req_opcode == sips_pkg::OP_APPEND || req_opcode == sips_pkg::OP_QUERY)
		|=> !req_ready)
		else $error("item taken while append or query in progress");

	// A clear completes in its own beat
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && req_opcode == sips_pkg::OP_CLEAR |=> req_ready)
		else $error("block not ready after clear");

endmodule

bind sorted_insert_position_search sips_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_opcode   (req.opcode),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_position (rsp.position),
	.rsp_found    (rsp.found),
	.rsp_overflow (rsp.overflow)
);

`default_nettype wire

>>> tb/sv/insert_position_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted insert-position search block: watches the item and result
// channels, keeps its own copy of the key table and compares every result beat.
// Depends on sips_pkg for widths and operation codes.

module insert_position_checker
	import sips_pkg::*;
#(
	parameter int unsigned DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [OP_W-1:0]         in_opcode,
	input  logic signed [KEY_W-1:0] in_key,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [POS_W-1:0]        out_position,
	input  logic                    out_found,
	input  logic                    out_overflow,
	output int unsigned             mismatches,
	output int unsigned             awaited,
	output int unsigned             results_checked,
	output int unsigned             hits_seen,
	output int unsigned             overflows_seen
);

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             found;
		logic             overflow;
	} position_result_t;

	// Shadow table: only entries below fill_level are ever read
	logic signed [KEY_W-1:0] stored_keys [DEPTH];
	int unsigned             fill_level = 0;
	position_result_t        expected_results [$];
	int unsigned             errors = 0;
	int unsigned             checked = 0;
	int unsigned             hits = 0;
	int unsigned             overflows = 0;

	initial begin
		mismatches      = 0;
		awaited         = 0;
		results_checked = 0;
		hits_seen       = 0;
		overflows_seen  = 0;
	end

	// Binary search over the live entries; stops on the first equal probe
	function automatic position_result_t search_position(input logic signed [KEY_W-1:0] k);
		int               lo;
		int               hi;
		int               mid;
		position_result_t r;
		lo = 0;
		hi = int'(fill_level) - 1;
		r  = '0;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (k == stored_keys[mid]) begin
				r.position = POS_W'(mid);
				r.found    = 1'b1;
				return r;
			end
			if (k > stored_keys[mid])
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		r.position = POS_W'(lo);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		position_result_t want;
		position_result_t got;
		if (!arst_n) begin
			fill_level = 0;
			expected_results.delete();
			awaited <= 0;
		end else begin
			// Predict the result of an accepted item beat
			if (in_valid && in_ready) begin
				case (in_opcode)
				OP_CLEAR: fill_level = 0;
				OP_APPEND: begin
					want          = '0;
					want.position = POS_W'(fill_level);
					if (fill_level >= DEPTH) begin
						want.overflow = 1'b1;
					end else begin
						stored_keys[fill_level] = in_key;
						fill_level++;
					end
					expected_results.push_back(want);
				end
				OP_QUERY: expected_results.push_back(search_position(in_key));
				default: ;
				endcase
			end

			// Compare a result beat with the oldest prediction
			if (out_valid && out_ready) begin
				got = '{position: out_position, found: out_found, overflow: out_overflow};
				if (expected_results.size() == 0) begin
					if (errors < 10)
						$display("%0t: result beat with nothing pending: pos %0d found %0b ovf %0b",
							$time, got.position, got.found, got.overflow);
					errors++;
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (got.position !== want.position || got.found !== want.found ||
							got.overflow !== want.overflow) begin
						if (errors < 10)
							$display("%0t: mismatch: expected pos %0d found %0b ovf %0b, got pos %0d found %0b ovf %0b",
								$time, want.position, want.found, want.overflow,
								got.position, got.found, got.overflow);
						errors++;
					end
					if (want.found)
						hits++;
					if (want.overflow)
						overflows++;
				end
			end

			mismatches      <= errors;
			awaited         <= expected_results.size();
			results_checked <= checked;
			hits_seen       <= hits;
			overflows_seen  <= overflows;
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the sorted insert-position search block: clock, reset,
// item stimulus, receiver stalls, watchdog and verdict.
// Depends on sips_pkg, sips_if, the block itself and insert_position_checker.

module tb
	import sips_pkg::*;
;

	localparam int unsigned TABLE_DEPTH     = DEF_TABLE_DEPTH;
	localparam int unsigned ITEM_TARGET     = 1350;
	localparam int unsigned BIG_FILL_AT     = 200;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned IDLE_LIMIT      = 4000;
	localparam int unsigned DRAIN_CYCLES    = 40;

	localparam logic [OP_W-1:0]         OP_UNUSED = 2'd3;
	localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX   = 32'sh7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;

	sips_in_if  in_ch ();
	sips_out_if out_ch ();

	int unsigned mismatches;
	int unsigned awaited;
	int unsigned results_checked;
	int unsigned hits_seen;
	int unsigned overflows_seen;

	// Stimulus bookkeeping
	int unsigned             items_sent   = 0;
	int unsigned             clears_sent  = 0;
	int unsigned             appends_sent = 0;
	int unsigned             queries_sent = 0;
	int unsigned             ignored_sent = 0;
	int                      burst_left   = 1;
	logic signed [KEY_W-1:0] shadow_keys [$];
	bit                      hold_off_go  = 1'b0;
	int unsigned             idle_cycles  = 0;

	always #5 clk = ~clk;

	sorted_insert_position_search #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (in_ch),
		.rsp   (out_ch)
	);

	insert_position_checker #(
		.DEPTH(TABLE_DEPTH)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.in_opcode      (in_ch.opcode),
		.in_key         (in_ch.key),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_position   (out_ch.position),
		.out_found      (out_ch.found),
		.out_overflow   (out_ch.overflow),
		.mismatches     (mismatches),
		.awaited        (awaited),
		.results_checked(results_checked),
		.hits_seen      (hits_seen),
		.overflows_seen (overflows_seen)
	);

	// Offer one item beat, hold it until accepted, then maybe drop valid for a gap
	task automatic send_item(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] k);
		int unsigned gap;
		in_ch.valid  <= 1'b1;
		in_ch.opcode <= op;
		in_ch.key    <= k;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		case (op)
		OP_CLEAR: begin
			clears_sent++;
			shadow_keys.delete();
		end
		OP_APPEND: begin
			appends_sent++;
			if (shadow_keys.size() < TABLE_DEPTH)
				shadow_keys.push_back(k);
		end
		OP_QUERY: queries_sent++;
		default: ignored_sent++;
		endcase
		if (op != OP_UNUSED)
			items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	// Append a run of keys: ascending with bounded steps, or small keys in any order
	task automatic load_table(input int count, input longint first, input int unsigned step_max,
			input bit scrambled);
		longint k;
		k = first;
		for (int i = 0; i < count; i++) begin
			if (scrambled)
				k = longint'(int'($urandom_range(0, 31)) - 16);
			send_item(OP_APPEND, 32'(k));
			if (!scrambled) begin
				k = k + longint'($urandom_range(0, step_max));
				if (k > longint'(KEY_MAX))
					k = longint'(KEY_MAX);
			end
		end
	endtask

	// Mostly aim at stored keys and their neighbours, sometimes at the extremes or at random keys
	function automatic logic signed [KEY_W-1:0] pick_query_key();
		int unsigned             r;
		logic signed [KEY_W-1:0] base;
		r = $urandom_range(0, 9);
		if (shadow_keys.size() == 0 || r >= 8)
			return $urandom;
		base = shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
		case (r)
		0, 1, 2, 3: return base;
		4, 5: return base + 1;
		6: return base - 1;
		default: return ($urandom_range(0, 1) != 0) ? KEY_MAX : KEY_MIN;
		endcase
	endfunction

	task automatic ask_queries(input int count);
		for (int i = 0; i < count; i++)
			send_item(OP_QUERY, pick_query_key());
	endtask

	// Receiver: stall patterns that change every so often, plus one long hold-off
	initial begin
		int unsigned mode;
		int unsigned span;
		bit          held;
		held = 1'b0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 150);
			for (int c = 0; c < span; c++) begin
				if (hold_off_go && !held) begin
					out_ch.ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
					held = 1'b1;
				end
				case (mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				2: out_ch.ready <= (c % 7) >= 3;
				default: out_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned pick;
		bit          big_fill_done;
		big_fill_done = 1'b0;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.opcode  = OP_CLEAR;
		in_ch.key     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extreme keys, duplicates, unused code, broken order
		send_item(OP_QUERY, 32'sd0);
		send_item(OP_APPEND, KEY_MIN);
		send_item(OP_APPEND, -32'sd1);
		send_item(OP_APPEND, 32'sd0);
		send_item(OP_APPEND, 32'sd0);
		send_item(OP_APPEND, KEY_MAX);
		send_item(OP_QUERY, KEY_MIN);
		send_item(OP_QUERY, KEY_MAX);
		send_item(OP_QUERY, 32'sd0);
		send_item(OP_QUERY, 32'sd5);
		send_item(OP_QUERY, -32'sd5);
		send_item(OP_UNUSED, 32'shAAAA_AAAA);
		send_item(OP_APPEND, 32'sd7);
		send_item(OP_QUERY, 32'sd7);
		send_item(OP_CLEAR, 32'sh5555_5555);
		send_item(OP_QUERY, KEY_MIN);
		send_item(OP_APPEND, 32'sh5555_5555);
		send_item(OP_QUERY, 32'sh5555_5556);
		send_item(OP_UNUSED, 32'sh5555_5555);
		send_item(OP_QUERY, KEY_MIN);

		// Random: mostly clear, ascending fill and queries; one full-table run
		while (items_sent < ITEM_TARGET) begin
			if (!big_fill_done && items_sent >= BIG_FILL_AT) begin
				send_item(OP_CLEAR, $urandom);
				hold_off_go <= 1'b1;
				load_table(TABLE_DEPTH + 4, longint'(KEY_MIN) + longint'($urandom_range(0, 2)),
					32'h0040_0000, 1'b0);
				ask_queries(80);
				big_fill_done = 1'b1;
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					send_item(OP_CLEAR, $urandom);
					if (pick < 4)
						load_table($urandom_range(0, 24),
							longint'(int'($urandom_range(0, 40)) - 20), 2, 1'b0);
					else
						load_table($urandom_range(0, 24), longint'($signed($urandom)),
							32'h0100_0000, 1'b0);
					ask_queries($urandom_range(1, 12));
				end else if (pick == 7) begin
					// extend whatever is there; order may break
					load_table($urandom_range(1, 6), longint'($signed($urandom)),
						32'h0100_0000, 1'b0);
					ask_queries($urandom_range(1, 6));
				end else if (pick == 8) begin
					repeat ($urandom_range(1, 6))
						send_item(OP_W'($urandom_range(0, 3)), $urandom);
				end else begin
					send_item(OP_CLEAR, $urandom);
					load_table($urandom_range(1, 16), 0, 0, 1'b1);
					ask_queries($urandom_range(2, 10));
				end
			end
		end
		in_ch.valid <= 1'b0;

		// Drain outstanding results, then let the block settle
		do @(posedge clk); while (awaited != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d items (%0d clears, %0d appends, %0d queries), %0d unused-code beats.",
			items_sent, clears_sent, appends_sent, queries_sent, ignored_sent);
		$display("Results: %0d checked, %0d query hits, %0d appends dropped on a full table, %0d mismatches.",
			results_checked, hits_seen, overflows_seen, mismatches);
		if (mismatches == 0 && awaited == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/sips_pkg.sv
rtl/sips_if.sv
rtl/sips_ram.sv
rtl/sips_dp.sv
rtl/sips_ctrl.sv
rtl/sorted_insert_position_search.sv
rtl/sips_chk.sv
tb/sv/insert_position_checker.sv
tb/sv/tb.sv
